// ===== sv/png_text_chunk_framer_defines.svh =====
// assertion macros shared by the framer modules
`ifndef PNG_TEXT_CHUNK_FRAMER_DEFINES_SVH
`define PNG_TEXT_CHUNK_FRAMER_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define PTCF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define PTCF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ptcf_pkg.sv =====
// shared types, constants and the bytewise crc-32 step for the chunk framer
package ptcf_pkg;

	localparam int DataLenW = 12;
	localparam int PosW = 13;
	localparam int CrcW = 32;
	localparam int HeadBytes = 8;
	localparam int FrameExtra = 12;
	localparam int MaxDataLengthDef = 4095;
	localparam int MaxPos = 4095 + FrameExtra - 1;

	localparam logic [7:0] PadByte = 8'h20;
	localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

	// chunk type, in transmission order
	localparam logic [7:0] TypeBytes [4] = '{8'h74, 8'h45, 8'h58, 8'h74};

	// configuration register indexes
	localparam logic CfgDataLength = 1'b0;
	localparam logic CfgContentLength = 1'b1;

	typedef struct packed {
		logic start_req;
		logic [7:0] content_byte;
	} item_t;

	// one byte through the reflected crc-32, lsb first
	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
		input logic [7:0] b);
		logic [CrcW-1:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
		end
		return c;
	endfunction

endpackage

// ===== sv/ptcf_in_if.sv =====
// input channel: start request and content byte with valid/ready
interface ptcf_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic [7:0] content_byte;

	modport source (output valid, output start_req, output content_byte, input ready);
	modport sink (input valid, input start_req, input content_byte, output ready);
endinterface

// ===== sv/ptcf_out_if.sv =====
// output channel: chunk byte with its flags, valid/ready
interface ptcf_out_if;
	logic valid;
	logic ready;
	logic [7:0] chunk_byte;
	logic took_content;
	logic last_byte;

	modport source (output valid, output chunk_byte, output took_content, output last_byte,
		input ready);
	modport sink (input valid, input chunk_byte, input took_content, input last_byte,
		output ready);
endinterface

// ===== sv/ptcf_in_stage.sv =====
// input register stage of the chunk framer
`include "png_text_chunk_framer_defines.svh"

module ptcf_in_stage (
	input  logic clk,
	input  logic arst_n,
	ptcf_in_if.sink in_ch,
	input  logic take,
	output logic item_valid,
	output ptcf_pkg::item_t item
);

	logic valid_s1;
	ptcf_pkg::item_t item_s1;
	logic accept;

	assign in_ch.ready = !valid_s1 || take;
	assign accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.start_req <= in_ch.start_req;
			item_s1.content_byte <= in_ch.content_byte;
		end
	end

	assign item_valid = valid_s1;
	assign item = item_s1;

	`PTCF_ASSERT_NXT(a_hold_s1, valid_s1 && !take, valid_s1 && $stable(item_s1), "stage 1 word lost while waiting")

endmodule

// ===== sv/ptcf_core.sv =====
// framing sequencer, crc-32 update and output register
`include "png_text_chunk_framer_defines.svh"

module ptcf_core #(
	parameter int MAX_DATA_LENGTH = ptcf_pkg::MaxDataLengthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [ptcf_pkg::DataLenW-1:0] data_length,
	input  logic [ptcf_pkg::DataLenW-1:0] text_len,
	input  logic item_valid,
	input  ptcf_pkg::item_t item,
	output logic take,
	ptcf_out_if.source out_ch
);

	localparam int SatLen = (MAX_DATA_LENGTH > 4095) ? 4095 : MAX_DATA_LENGTH;

	logic [ptcf_pkg::PosW-1:0] pos_q;
	logic [ptcf_pkg::CrcW-1:0] crc_q;
	logic out_valid_q;
	logic [7:0] chunk_byte_q;
	logic took_q;
	logic last_q;

	logic [ptcf_pkg::DataLenW-1:0] dlen;
	logic [ptcf_pkg::DataLenW-1:0] clen;
	logic [ptcf_pkg::PosW-1:0] total;
	logic [ptcf_pkg::PosW-1:0] data_end;
	logic [ptcf_pkg::PosW-1:0] pos;
	logic [ptcf_pkg::PosW-1:0] data_idx;
	logic [ptcf_pkg::PosW-1:0] k;
	logic [ptcf_pkg::CrcW-1:0] crc_cur;
	logic [ptcf_pkg::CrcW-1:0] crc_fin;
	logic [ptcf_pkg::CrcW-1:0] crc_nxt;
	logic restart;
	logic [7:0] b;
	logic took;
	logic last;
	logic upd;

	assign take = item_valid && (!out_valid_q || out_ch.ready);

	always_comb begin
		dlen = (data_length > ptcf_pkg::DataLenW'(SatLen)) ?
			ptcf_pkg::DataLenW'(SatLen) : data_length;
		clen = (text_len < dlen) ? text_len : dlen;
		total = {1'b0, dlen} + ptcf_pkg::PosW'(ptcf_pkg::FrameExtra);
		data_end = {1'b0, dlen} + ptcf_pkg::PosW'(ptcf_pkg::HeadBytes);
		restart = item.start_req || (pos_q >= total);
		pos = restart ? '0 : pos_q;
		crc_cur = restart ? ptcf_pkg::CrcInit : crc_q;
		crc_fin = ~crc_cur;
		data_idx = pos - ptcf_pkg::PosW'(ptcf_pkg::HeadBytes);
		k = pos - data_end;
		b = '0;
		took = 1'b0;
		last = 1'b0;
		upd = 1'b0;
		if (pos < ptcf_pkg::PosW'(4)) begin
			// big-endian length, top bytes are zero
			case (pos[1:0])
				2'd2: b = {4'd0, dlen[11:8]};
				2'd3: b = dlen[7:0];
				default: b = '0;
			endcase
		end else if (pos < ptcf_pkg::PosW'(ptcf_pkg::HeadBytes)) begin
			b = ptcf_pkg::TypeBytes[pos[1:0]];
			upd = 1'b1;
		end else if (pos < data_end) begin
			if (data_idx < {1'b0, clen}) begin
				b = item.content_byte;
				took = 1'b1;
			end else begin
				b = ptcf_pkg::PadByte;
			end
			upd = 1'b1;
		end else begin
			case (k[1:0])
				2'd0: b = crc_fin[31:24];
				2'd1: b = crc_fin[23:16];
				2'd2: b = crc_fin[15:8];
				default: b = crc_fin[7:0];
			endcase
			last = (k == ptcf_pkg::PosW'(3));
		end
		crc_nxt = upd ? ptcf_pkg::crc_byte(crc_cur, b) : crc_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= ptcf_pkg::CrcInit;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				pos_q <= last ? '0 : pos + ptcf_pkg::PosW'(1);
				crc_q <= last ? ptcf_pkg::CrcInit : crc_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			chunk_byte_q <= b;
			took_q <= took;
			last_q <= last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.chunk_byte = chunk_byte_q;
	assign out_ch.took_content = took_q;
	assign out_ch.last_byte = last_q;

	`PTCF_ASSERT_IMP(a_last_no_content, out_valid_q && last_q, !took_q, "content taken on final crc byte")
	`PTCF_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= ptcf_pkg::PosW'(ptcf_pkg::MaxPos), "position past any chunk end")
	`PTCF_ASSERT_NXT(a_wrap, take && last, pos_q == '0 && crc_q == ptcf_pkg::CrcInit, "chunk end did not rearm")

endmodule

// ===== sv/png_text_chunk_framer.sv =====
// top level of the png text chunk framer
// usage
//   in_ch carries one word per byte slot: start_req and content_byte
//   out_ch returns one word per input word: chunk_byte, took_content, last_byte
//   a chunk is 4 length bytes, 'tEXt', data_length data bytes and a 4-byte crc-32,
//   so it spans data_length + 12 words; last_byte marks the final crc byte
//   data bytes take content_byte for the first text_len slots, then spaces
//   start_req on any word restarts the chunk at its first length byte
// throughput and pipeline
//   one word per cycle sustained while out_ch.ready is high; the crc-32 byte step is
//   combinational; a word passes through the input register, then the output register,
//   before it shows on out_ch; in_ch.ready stays high while the output register drains
// stall and reset
//   if out_ch.ready is low the result holds, one more word waits in stage 1,
//   then in_ch.ready drops until the receiver takes the result
//   arst_n clears both stages, sets the position to the length byte and the crc
//   to all ones; data_length resets to 48 and the text length to 0
//   registers are written through cfg_we/cfg_index/cfg_wdata; the user must write them while idle only, not enforced
module png_text_chunk_framer #(
	parameter int MAX_DATA_LENGTH = ptcf_pkg::MaxDataLengthDef
) (
	input  logic clk,
	input  logic arst_n,
	ptcf_in_if.sink in_ch,
	ptcf_out_if.source out_ch,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [ptcf_pkg::DataLenW-1:0] cfg_wdata
);

	// configuration registers
	logic [ptcf_pkg::DataLenW-1:0] data_length_q;
	logic [ptcf_pkg::DataLenW-1:0] text_len_q;

	// stage 1 to core
	logic item_valid;
	ptcf_pkg::item_t item;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= ptcf_pkg::DataLenW'(48);
			text_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptcf_pkg::CfgDataLength: data_length_q <= cfg_wdata;
				ptcf_pkg::CfgContentLength: text_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register, frees itself when the core takes the word
	ptcf_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.take(take),
		.item_valid(item_valid),
		.item(item)
	);

	// framing, crc and output register
	ptcf_core #(
		.MAX_DATA_LENGTH(MAX_DATA_LENGTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.data_length(data_length_q),
		.text_len(text_len_q),
		.item_valid(item_valid),
		.item(item),
		.take(take),
		.out_ch(out_ch)
	);

endmodule
